### hdl/urip_pkg.sv
// ----------------------------------------------------------------------------
// urip_pkg
// Types and constants shared by the idle-timeout serial packetizer.
// ----------------------------------------------------------------------------
package urip_pkg;

   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic [1:0] MODE_BYTE  = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_ROUTE = 2'd2;

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_IDLE = 2'd1;
   localparam logic [1:0] KIND_DROP = 2'd2;

   localparam logic [1:0] REG_PACKET_LIMIT  = 2'd0;
   localparam logic [1:0] REG_IDLE_GAP      = 2'd1;
   localparam logic [1:0] REG_ROUTE_TIMEOUT = 2'd2;

   localparam logic [7:0]  PACKET_LIMIT_RESET  = 8'd120;
   localparam logic [7:0]  IDLE_GAP_RESET      = 8'd2;
   localparam logic [15:0] ROUTE_TIMEOUT_RESET = 16'd3000;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] rx_byte;
      logic [6:0] source_node;
      logic [7:0] route_protocol;
   } urip_req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       packet_end;
      logic [7:0] packet_length;
      logic [6:0] dest_node;
      logic [7:0] dest_protocol;
   } urip_rsp_type;

endpackage

### hdl/uart_rx_idle_packetizer.sv
// ----------------------------------------------------------------------------
// uart_rx_idle_packetizer
// Groups received serial bytes into packets routed to one remote node.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/ready     urip_req_type
//   rsp      out        rsp_valid/ready     urip_rsp_type
//   csr      in/out     APB, pready high    packet_limit, idle_gap, timeout
//
// One transaction is accepted per cycle; its result is registered in the
// result register, or in the skid register while the output stalls. A
// two-entry output buffer (result register plus skid register) sets the
// rate: input stalls only when both entries are full. Reset is synchronous.
// ----------------------------------------------------------------------------
module uart_rx_idle_packetizer
   import urip_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  urip_req_type              req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output urip_rsp_type              rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [7:0]   packet_limit_ff;
   logic [7:0]   idle_gap_ff;
   logic [15:0]  route_timeout_ff;

   logic         route_ok_ff, route_ok_in;
   logic [6:0]   remote_node_ff, remote_node_in;
   logic [7:0]   route_proto_ff, route_proto_in;
   logic [7:0]   open_count_ff, open_count_in;
   logic [15:0]  route_age_ff, route_age_in;
   logic [7:0]   idle_age_ff, idle_age_in;

   logic         out_valid_ff, out_valid_in;
   urip_rsp_type out_ff, out_in;
   logic         skid_valid_ff, skid_valid_in;
   urip_rsp_type skid_ff, skid_in;

   logic         req_fire;
   logic         csr_write;
   logic [1:0]   csr_index;
   logic [7:0]   byte_len;
   logic         byte_end;
   logic         res_valid;
   urip_rsp_type res;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_comb begin
      case (csr_index)
         REG_PACKET_LIMIT:  csr_prdata = {24'd0, packet_limit_ff};
         REG_IDLE_GAP:      csr_prdata = {24'd0, idle_gap_ff};
         REG_ROUTE_TIMEOUT: csr_prdata = {16'd0, route_timeout_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_limit_ff  <= PACKET_LIMIT_RESET;
         idle_gap_ff      <= IDLE_GAP_RESET;
         route_timeout_ff <= ROUTE_TIMEOUT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_PACKET_LIMIT:  packet_limit_ff  <= csr_pwdata[7:0];
            REG_IDLE_GAP:      idle_gap_ff      <= csr_pwdata[7:0];
            REG_ROUTE_TIMEOUT: route_timeout_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign byte_len  = open_count_ff + 8'd1;
   assign byte_end  = (byte_len >= packet_limit_ff);

   always_comb begin
      route_ok_in    = route_ok_ff;
      remote_node_in = remote_node_ff;
      route_proto_in = route_proto_ff;
      open_count_in  = open_count_ff;
      route_age_in   = route_age_ff;
      idle_age_in    = idle_age_ff;
      res_valid      = 1'b0;
      res.kind          = KIND_BYTE;
      res.data_byte     = 8'd0;
      res.packet_end    = 1'b0;
      res.packet_length = open_count_ff;
      res.dest_node     = remote_node_ff;
      res.dest_protocol = route_proto_ff;
      if (req_fire) begin
         case (req_payload.mode)
            MODE_BYTE: begin
               if (route_ok_ff) begin
                  idle_age_in       = 8'd0;
                  open_count_in     = byte_end ? 8'd0 : byte_len;
                  res_valid         = 1'b1;
                  res.data_byte     = req_payload.rx_byte;
                  res.packet_end    = byte_end;
                  res.packet_length = byte_len;
               end
            end
            MODE_TICK: begin
               if (route_age_ff != 16'hFFFF) begin
                  route_age_in = route_age_ff + 16'd1;
               end
               if (idle_age_ff != 8'hFF) begin
                  idle_age_in = idle_age_ff + 8'd1;
               end
               if (route_ok_ff && (route_age_in >= route_timeout_ff)) begin
                  route_ok_in   = 1'b0;
                  open_count_in = 8'd0;
                  res_valid     = (open_count_ff != 8'd0);
                  res.kind      = KIND_DROP;
               end else if (route_ok_ff && (open_count_ff != 8'd0) &&
                            ((idle_age_in >= idle_gap_ff) ||
                             (open_count_ff >= packet_limit_ff))) begin
                  open_count_in = 8'd0;
                  res_valid     = 1'b1;
                  res.kind      = KIND_IDLE;
               end
            end
            MODE_ROUTE: begin
               remote_node_in = req_payload.source_node;
               route_proto_in = req_payload.route_protocol;
               route_age_in   = 16'd0;
               route_ok_in    = (req_payload.source_node != 7'd0);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_in       = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_ok_ff    <= 1'b0;
         remote_node_ff <= 7'd0;
         route_proto_ff <= 8'd0;
         open_count_ff  <= 8'd0;
         route_age_ff   <= 16'd0;
         idle_age_ff    <= 8'd0;
         out_valid_ff   <= 1'b0;
         skid_valid_ff  <= 1'b0;
      end else begin
         route_ok_ff    <= route_ok_in;
         remote_node_ff <= remote_node_in;
         route_proto_ff <= route_proto_in;
         open_count_ff  <= open_count_in;
         route_age_ff   <= route_age_in;
         idle_age_ff    <= idle_age_in;
         out_valid_ff   <= out_valid_in;
         skid_valid_ff  <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a transaction while the output is empty.");

   a_open_count_bound: assert property (@(posedge clock) disable iff (reset)
      open_count_ff != 8'hFF)
      else $error("Open packet length reached an impossible value.");

   a_byte_without_route: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.mode == MODE_BYTE) && !route_ok_ff)
      |=> $stable(open_count_ff))
      else $error("A byte without a route changed the open packet.");

   a_no_route_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.mode == MODE_ROUTE)) |-> !res_valid)
      else $error("A route request produced a result.");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the idle-timeout serial packetizer against a cycle-free prediction.
// Received bytes, millisecond ticks and route requests are sent through the
// request channel with random gaps. Each result is compared with the oldest
// predicted packet event while the result side stalls at random. The limits
// are reprogrammed between phases, once the block has gone idle.
// ----------------------------------------------------------------------------
module testbench;
   import urip_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1500000;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   urip_req_type              req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   urip_rsp_type              rsp_payload;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   uart_rx_idle_packetizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   urip_req_type rx_queue[$];
   urip_rsp_type packet_results[$];

   int cfg_limit = int'(PACKET_LIMIT_RESET);
   int cfg_gap = int'(IDLE_GAP_RESET);
   int cfg_timeout = int'(ROUTE_TIMEOUT_RESET);

   bit route_live = 1'b0;
   logic [6:0] dest_node_q = '0;
   logic [7:0] dest_proto_q = '0;
   int open_len = 0;
   int route_ticks = 0;
   int idle_ticks = 0;

   int error_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int rsp_stall = 0;
   bit quiet_run = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_delay();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_run || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic void packetize_item(urip_req_type item);
      urip_rsp_type pkt;
      bit has_result;
      int len;
      pkt = '0;
      has_result = 1'b0;
      case (item.mode)
         MODE_BYTE: begin
            if (route_live) begin
               len = open_len + 1;
               pkt.kind = KIND_BYTE;
               pkt.data_byte = item.rx_byte;
               pkt.packet_end = (len >= cfg_limit);
               pkt.packet_length = len[7:0];
               idle_ticks = 0;
               open_len = pkt.packet_end ? 0 : len;
               has_result = 1'b1;
            end
         end
         MODE_TICK: begin
            if (route_ticks < 16'hFFFF) route_ticks++;
            if (idle_ticks < 8'hFF) idle_ticks++;
            if (route_live && route_ticks >= cfg_timeout) begin
               route_live = 1'b0;
               if (open_len > 0) begin
                  pkt.kind = KIND_DROP;
                  pkt.packet_length = open_len[7:0];
                  has_result = 1'b1;
               end
               open_len = 0;
            end else if (route_live && open_len > 0 &&
                         (idle_ticks >= cfg_gap || open_len >= cfg_limit)) begin
               pkt.kind = KIND_IDLE;
               pkt.packet_length = open_len[7:0];
               open_len = 0;
               has_result = 1'b1;
            end
         end
         MODE_ROUTE: begin
            dest_node_q = item.source_node;
            dest_proto_q = item.route_protocol;
            route_ticks = 0;
            route_live = (item.source_node != '0);
         end
         default: begin
         end
      endcase
      if (has_result) begin
         pkt.dest_node = dest_node_q;
         pkt.dest_protocol = dest_proto_q;
         packet_results.push_back(pkt);
      end
   endfunction

   always @(posedge clock) begin : req_side
      logic next_valid;
      urip_req_type next_payload;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         next_valid = req_valid;
         next_payload = req_payload;
         if (req_valid && req_ready) begin
            packetize_item(req_payload);
            next_valid = 1'b0;
            send_gap = pick_delay();
         end
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (rx_queue.size() != 0) begin
               next_payload = rx_queue.pop_front();
               next_valid = 1'b1;
            end
         end
         req_valid <= next_valid;
         req_payload <= next_payload;
      end
   end

   always @(posedge clock) begin : rsp_side
      urip_rsp_type want;
      logic next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (packet_results.size() == 0) begin
               $error("unexpected transaction: %p", rsp_payload);
               error_count++;
            end else begin
               want = packet_results.pop_front();
               if (rsp_payload.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_payload.kind);
                  error_count++;
               end
               if (rsp_payload.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0d, got %0d", want.data_byte,
                         rsp_payload.data_byte);
                  error_count++;
               end
               if (rsp_payload.packet_end !== want.packet_end) begin
                  $error("packet_end: expected %0d, got %0d", want.packet_end,
                         rsp_payload.packet_end);
                  error_count++;
               end
               if (rsp_payload.packet_length !== want.packet_length) begin
                  $error("packet_length: expected %0d, got %0d", want.packet_length,
                         rsp_payload.packet_length);
                  error_count++;
               end
               if (rsp_payload.dest_node !== want.dest_node) begin
                  $error("dest_node: expected %0d, got %0d", want.dest_node,
                         rsp_payload.dest_node);
                  error_count++;
               end
               if (rsp_payload.dest_protocol !== want.dest_protocol) begin
                  $error("dest_protocol: expected %0d, got %0d", want.dest_protocol,
                         rsp_payload.dest_protocol);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
            if ($urandom_range(0, 9) == 0) rsp_stall = pick_delay();
         end
         rsp_ready <= next_ready;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic urip_req_type random_item(logic [1:0] mode);
      urip_req_type item;
      item.mode = mode;
      item.rx_byte = 8'($urandom_range(0, 255));
      item.source_node = 7'($urandom_range(0, 127));
      item.route_protocol = 8'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic void push_item(logic [1:0] mode, logic [7:0] rx_byte,
                                     logic [6:0] node, logic [7:0] proto);
      urip_req_type item;
      item.mode = mode;
      item.rx_byte = rx_byte;
      item.source_node = node;
      item.route_protocol = proto;
      rx_queue.push_back(item);
   endfunction

   function automatic void push_route();
      urip_req_type item;
      item = random_item(MODE_ROUTE);
      item.source_node = 7'($urandom_range(1, 127));
      rx_queue.push_back(item);
   endfunction

   task automatic queue_traffic(int count);
      urip_req_type item;
      int n;
      int r;
      int run;
      n = 0;
      while (n < count) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            push_route();
            n++;
         end else if (r < 13) begin
            item = random_item(MODE_ROUTE);
            item.source_node = '0;
            rx_queue.push_back(item);
            n++;
         end else if (r < 15) begin
            rx_queue.push_back(random_item(MODE_UNUSED));
            n++;
         end else if (r < 60) begin
            run = (r < 55) ? $urandom_range(1, 6) : $urandom_range(1, cfg_limit + 2);
            if (run > count - n) run = count - n;
            repeat (run) rx_queue.push_back(random_item(MODE_BYTE));
            n += run;
         end else begin
            if (r < 90) run = $urandom_range(1, 3);
            else if (r < 97) run = $urandom_range(1, (cfg_gap + 2 > 300) ? 300 : cfg_gap + 2);
            else run = $urandom_range(1, (cfg_timeout + 2 > 300) ? 300 : cfg_timeout + 2);
            if (run > count - n) run = count - n;
            repeat (run) rx_queue.push_back(random_item(MODE_TICK));
            n += run;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (rx_queue.size() != 0 || req_valid || packet_results.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'({index, 2'b00});
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         REG_PACKET_LIMIT:  cfg_limit = int'(value[7:0]);
         REG_IDLE_GAP:      cfg_gap = int'(value[7:0]);
         REG_ROUTE_TIMEOUT: cfg_timeout = int'(value[15:0]);
         default: begin
         end
      endcase
   endtask

   initial begin
      int ph;
      int lim;
      int gap;
      int tmo;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Bytes before any route, the unused mode, then a packet closed by the idle gap.
      push_item(MODE_BYTE, 8'hFF, 7'h7F, 8'hFF);
      push_item(MODE_UNUSED, 8'hFF, 7'h7F, 8'hFF);
      push_item(MODE_ROUTE, 8'h00, 7'h7F, 8'hFF);
      push_item(MODE_BYTE, 8'h00, 7'h00, 8'h00);
      push_item(MODE_BYTE, 8'hFF, 7'h7F, 8'hFF);
      push_item(MODE_BYTE, 8'hA5, 7'h2A, 8'h5A);
      push_item(MODE_TICK, 8'h00, 7'h00, 8'h00);
      push_item(MODE_TICK, 8'hFF, 7'h7F, 8'hFF);
      // A zero source node parks the open packet until a new route arrives.
      push_item(MODE_BYTE, 8'h5A, 7'h00, 8'h00);
      push_item(MODE_ROUTE, 8'hFF, 7'h00, 8'h00);
      push_item(MODE_BYTE, 8'h3C, 7'h11, 8'h22);
      repeat (3) push_item(MODE_TICK, 8'h00, 7'h00, 8'h00);
      push_item(MODE_ROUTE, 8'h00, 7'h01, 8'h80);
      push_item(MODE_TICK, 8'h00, 7'h00, 8'h00);
      // Leave a packet open so that the next phase starts with a lowered limit.
      push_item(MODE_BYTE, 8'h11, 7'h00, 8'h00);
      push_item(MODE_BYTE, 8'h22, 7'h00, 8'h00);

      for (ph = 1; ph <= 9; ph++) begin
         wait_drained();
         case (ph)
            1: begin
               lim = 1;
               gap = 255;
               tmo = 65535;
            end
            2: begin
               lim = 255;
               gap = 1;
               tmo = 1;
            end
            3: begin
               lim = 0;
               gap = 0;
               tmo = 0;
            end
            default: begin
               lim = ($urandom_range(0, 4) == 0) ? 255 : $urandom_range(1, 12);
               gap = $urandom_range(1, 6);
               tmo = $urandom_range(4, 60);
            end
         endcase
         write_reg(REG_PACKET_LIMIT, lim);
         write_reg(REG_IDLE_GAP, gap);
         write_reg(REG_ROUTE_TIMEOUT, tmo);
         quiet_run = (ph == 2 || ph == 6);
         if (ph == 1) push_item(MODE_TICK, 8'h00, 7'h00, 8'h00);
         push_route();
         if (ph == 4) begin
            queue_traffic(40);
            wait_drained();
            queue_traffic(40);
         end else begin
            queue_traffic(80);
         end
      end
      wait_drained();

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
